>>> rtl/imhq_pkg.sv
//------------------------------------------------------------------------------
// imhq_pkg: shared types and constants
// Widths, operation and status codes, and sequencer states for the heap queue.
//------------------------------------------------------------------------------
package imhq_pkg;
	localparam int IdBits = 8;
	localparam int WBits = 32;
	localparam int Cap = 256;
	localparam int PosBits = 8;
	localparam int CntBits = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELMIN = 2'd1,
		OP_DECKEY = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_DUP      = 3'd3,
		ST_ABSENT   = 3'd4,
		ST_INCREASE = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DK_RD,
		S_DK_CHK,
		S_DM_RD,
		S_DM_LAST,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_DN_SW,
		S_DONE
	} state_t;

	// one port of the heap slot memory
	typedef struct packed {
		logic               we;
		logic [PosBits-1:0] addr;
		logic [IdBits-1:0]  wid;
		logic [WBits-1:0]   wwt;
	} hport_t;
endpackage

>>> rtl/imhq_heap_ram.sv
//------------------------------------------------------------------------------
// imhq_heap_ram: heap slot storage
// Two-port memory of (id, weight) slots with registered read data.
//------------------------------------------------------------------------------
module imhq_heap_ram import imhq_pkg::*; (
	input  logic              clk,
	input  hport_t            pa,
	input  hport_t            pb,
	output logic [IdBits-1:0] rid_a,
	output logic [WBits-1:0]  rwt_a,
	output logic [IdBits-1:0] rid_b,
	output logic [WBits-1:0]  rwt_b
);
	logic [IdBits+WBits-1:0] mem [Cap];

	always_ff @(posedge clk) begin
		if (pa.we) mem[pa.addr] <= {pa.wid, pa.wwt};
		if (pb.we) mem[pb.addr] <= {pb.wid, pb.wwt};
		{rid_a, rwt_a} <= mem[pa.addr];
		{rid_b, rwt_b} <= mem[pb.addr];
	end
endmodule

>>> rtl/imhq_pos_ram.sv
//------------------------------------------------------------------------------
// imhq_pos_ram: id to heap slot map
// Memory with two write ports and one registered read port.
//------------------------------------------------------------------------------
module imhq_pos_ram import imhq_pkg::*; (
	input  logic               clk,
	input  logic               we_a,
	input  logic [IdBits-1:0]  wa_a,
	input  logic [PosBits-1:0] wd_a,
	input  logic               we_b,
	input  logic [IdBits-1:0]  wa_b,
	input  logic [PosBits-1:0] wd_b,
	input  logic [IdBits-1:0]  ra,
	output logic [PosBits-1:0] rd
);
	logic [PosBits-1:0] mem [1<<IdBits];

	always_ff @(posedge clk) begin
		if (we_a) mem[wa_a] <= wd_a;
		if (we_b) mem[wa_b] <= wd_b;
		rd <= mem[ra];
	end
endmodule

>>> rtl/indexed_min_heap_queue.sv
//------------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap priority queue
// Insert, delete-min, decrease-key and contains on a heap of (id, weight).
//------------------------------------------------------------------------------
// channel  direction  handshake        payload
// in       input      valid / ready    mode, node_id, weight
// out      output     out_valid/ready  status, out_id, out_weight, found,
//                                      is_empty, entry_count
// Contains and requests rejected at acceptance go straight to the result.
// Insert and decrease-key climb the heap level by level and delete-min
// descends it level by level, each level using the two-port slot memory
// and the single weight comparator.
// Reset clears state, status, count and presence bits only; no clearing pass.
// ready is low from acceptance until the result is taken.
//------------------------------------------------------------------------------
module indexed_min_heap_queue import imhq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [1:0]         mode,
	input  logic [IdBits-1:0]  node_id,
	input  logic [WBits-1:0]   weight,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [IdBits-1:0]  out_id,
	output logic [WBits-1:0]   out_weight,
	output logic               found,
	output logic               is_empty,
	output logic [CntBits-1:0] entry_count
);
	state_t state_q, state_d;
	logic [CntBits-1:0] cnt_q;
	logic [Cap-1:0] pres_q;
	logic [IdBits-1:0] id_q;
	logic [WBits-1:0] w_q;
	logic [PosBits-1:0] k_q, j_q;
	logic [IdBits-1:0] kid_q;
	logic [WBits-1:0] kw_q;
	status_t st_q;
	logic [IdBits-1:0] oid_q;
	logic [WBits-1:0] ow_q;
	logic fnd_q;

	hport_t pa, pb;
	logic [IdBits-1:0] rid_a, rid_b;
	logic [WBits-1:0] rwt_a, rwt_b;
	logic pwe_a, pwe_b;
	logic [IdBits-1:0] pwa_a, pwa_b, pra;
	logic [PosBits-1:0] pwd_a, pwd_b, prd;

	imhq_heap_ram u_heap (
		.clk, .pa, .pb, .rid_a, .rwt_a, .rid_b, .rwt_b
	);
	imhq_pos_ram u_pos (
		.clk, .we_a(pwe_a), .wa_a(pwa_a), .wd_a(pwd_a),
		.we_b(pwe_b), .wa_b(pwa_b), .wd_b(pwd_b), .ra(pra), .rd(prd)
	);

	// shared comparator
	logic [WBits-1:0] cmp_a, cmp_b;
	logic gt;
	assign gt = cmp_a > cmp_b;

	logic [PosBits-1:0] par, lch;
	logic [CntBits-1:0] lch_w;
	assign par = PosBits'((k_q - 1'b1) >> 1);
	assign lch_w = {k_q, 1'b0} + 1'b1;
	assign lch = lch_w[PosBits-1:0];

	assign ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = st_q;
	assign out_id = oid_q;
	assign out_weight = ow_q;
	assign found = fnd_q;
	assign is_empty = (cnt_q == '0);
	assign entry_count = cnt_q;

	logic acc;
	assign acc = valid && ready;
	assign pra = acc ? node_id : id_q;

	// next-state and datapath controls
	logic ld_k, ld_j, ld_kw, set_st, cnt_inc, cnt_dec, pres_set, pres_clr;
	logic [PosBits-1:0] k_d, j_d;
	logic [WBits-1:0] kw_d;
	status_t st_d;

	always_comb begin
		state_d = state_q;
		pa = '0; pb = '0;
		pwe_a = 1'b0; pwa_a = kid_q; pwd_a = k_q;
		pwe_b = 1'b0; pwa_b = kid_q; pwd_b = k_q;
		cmp_a = rwt_a; cmp_b = kw_q;
		ld_k = 1'b0; ld_j = 1'b0; ld_kw = 1'b0; set_st = 1'b0;
		k_d = k_q; j_d = j_q; kw_d = kw_q; st_d = ST_OK;
		cnt_inc = 1'b0; cnt_dec = 1'b0; pres_set = 1'b0; pres_clr = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_DK_RD: begin
				pa.addr = prd;
				ld_k = 1'b1; k_d = prd;
				state_d = S_DK_CHK;
			end
			S_DK_CHK: begin
				cmp_a = w_q; cmp_b = rwt_a;
				if (CntBits'(k_q) >= cnt_q) begin
					set_st = 1'b1; st_d = ST_ABSENT; state_d = S_DONE;
				end else if (gt) begin
					set_st = 1'b1; st_d = ST_INCREASE; state_d = S_DONE;
				end else begin
					pa.we = 1'b1; pa.addr = k_q; pa.wid = id_q; pa.wwt = w_q;
					state_d = S_UP_RD;
				end
			end
			S_DM_RD: begin
				// root on port a, last on port b; addresses held for one more read
				pa.addr = '0;
				pb.addr = PosBits'(cnt_q - 1'b1);
				pres_clr = 1'b1; cnt_dec = 1'b1;
				state_d = S_DM_LAST;
			end
			S_DM_LAST: begin
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end else begin
					pa.we = 1'b1; pa.addr = '0; pa.wid = rid_b; pa.wwt = rwt_b;
					pwe_a = 1'b1; pwa_a = rid_b; pwd_a = '0;
					ld_k = 1'b1; k_d = '0; ld_kw = 1'b1; kw_d = rwt_b;
					state_d = S_DN_RD;
				end
			end
			S_UP_RD: begin
				if (k_q == '0) state_d = S_DONE;
				else begin
					pa.addr = par;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (gt) begin
					pa.we = 1'b1; pa.addr = k_q; pa.wid = rid_a; pa.wwt = rwt_a;
					pb.we = 1'b1; pb.addr = par; pb.wid = kid_q; pb.wwt = kw_q;
					pwe_a = 1'b1; pwa_a = rid_a; pwd_a = k_q;
					pwe_b = 1'b1; pwa_b = kid_q; pwd_b = par;
					ld_k = 1'b1; k_d = par;
					state_d = S_UP_RD;
				end else state_d = S_DONE;
			end
			S_DN_RD: begin
				if (lch_w >= cnt_q || lch_w >= CntBits'(Cap)) state_d = S_DONE;
				else begin
					pa.addr = lch; pb.addr = lch + 1'b1;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				// pick child: right only if left strictly heavier
				cmp_a = rwt_a; cmp_b = rwt_b;
				ld_j = 1'b1;
				if ((CntBits'(lch) + 1'b1) < cnt_q && gt) begin
					j_d = lch + 1'b1;
					pa.addr = lch + 1'b1;
				end else begin
					j_d = lch;
					pa.addr = lch;
				end
				state_d = S_DN_SW;
			end
			S_DN_SW: begin
				cmp_a = kw_q; cmp_b = rwt_a;
				if (gt) begin
					pa.we = 1'b1; pa.addr = k_q; pa.wid = rid_a; pa.wwt = rwt_a;
					pb.we = 1'b1; pb.addr = j_q; pb.wid = kid_q; pb.wwt = kw_q;
					pwe_a = 1'b1; pwa_a = rid_a; pwd_a = k_q;
					pwe_b = 1'b1; pwa_b = kid_q; pwd_b = j_q;
					ld_k = 1'b1; k_d = j_q;
					state_d = S_DN_RD;
				end else state_d = S_DONE;
			end
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (acc) begin
			set_st = 1'b1; st_d = ST_OK;
			unique case (op_t'(mode))
				OP_INSERT: begin
					if (cnt_q >= CntBits'(Cap)) begin
						st_d = ST_FULL; state_d = S_DONE;
					end else if (pres_q[node_id]) begin
						st_d = ST_DUP; state_d = S_DONE;
					end else begin
						pa.we = 1'b1; pa.addr = cnt_q[PosBits-1:0];
						pa.wid = node_id; pa.wwt = weight;
						pwe_a = 1'b1; pwa_a = node_id; pwd_a = cnt_q[PosBits-1:0];
						pres_set = 1'b1; cnt_inc = 1'b1;
						ld_k = 1'b1; k_d = cnt_q[PosBits-1:0];
						state_d = S_UP_RD;
					end
				end
				OP_DELMIN: begin
					if (cnt_q == '0) begin
						st_d = ST_EMPTY; state_d = S_DONE;
					end else begin
						pa.addr = '0;
						pb.addr = PosBits'(cnt_q - 1'b1);
						state_d = S_DM_RD;
					end
				end
				OP_DECKEY: begin
					if (!pres_q[node_id]) begin
						st_d = ST_ABSENT; state_d = S_DONE;
					end else state_d = S_DK_RD;
				end
				OP_QUERY: state_d = S_DONE;
				default: state_d = S_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pres_q <= '0;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (set_st) st_q <= st_d;
			if (cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cnt_dec) cnt_q <= cnt_q - 1'b1;
			if (pres_set) pres_q[node_id] <= 1'b1;
			if (pres_clr) pres_q[rid_a] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			id_q <= node_id;
			w_q <= weight;
			kid_q <= node_id;
			kw_q <= weight;
			oid_q <= '0;
			ow_q <= '0;
			fnd_q <= (op_t'(mode) == OP_QUERY) && pres_q[node_id];
		end else begin
			if (ld_kw) kw_q <= kw_d;
			if (state_q == S_DM_RD) begin
				oid_q <= rid_a;
				ow_q <= rwt_a;
			end
			if (state_q == S_DM_LAST) kid_q <= rid_b;
		end
		if (ld_k) k_q <= k_d;
		if (ld_j) j_q <= j_d;
	end

	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntBits'(Cap)) else $error("count overflow");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !ready)
		else $error("accepted while busy");
	ap_dm_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DM_RD) |-> (cnt_q != '0)) else $error("delete on empty");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(cnt_q))
		else $error("result dropped");
endmodule
